[rtl/psd_pkg.sv]
`default_nettype none

package psd_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_FUSE_MODE     = 2'd0;
    localparam logic [1:0] REG_STARTUP_ABS   = 2'd1;
    localparam logic [1:0] REG_INSERT_NEEDED = 2'd2;
    localparam logic [1:0] REG_ABSENT_GRACE  = 2'd3;

    localparam logic [1:0] ST_ABSENT   = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_CONSUMED = 2'd2;
    localparam logic [1:0] ST_SERVICE  = 2'd3;

    localparam logic [15:0] SERVICE_CODE = 16'h0202;
    localparam logic [15:0] MARKER_BLANK = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX    = 8'hFF;

    localparam logic        FUSE_MODE_RST     = 1'b1;
    localparam logic [7:0]  STARTUP_ABS_RST   = 8'd10;
    localparam logic [7:0]  INSERT_NEEDED_RST = 8'd5;
    localparam logic [31:0] ABSENT_GRACE_RST  = 32'd1000;

    typedef struct packed {
        logic        action;
        logic        probe_ok;
        logic [15:0] service_word;
        logic [15:0] marker_word;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] stable_out;
        logic       first_confirmed;
        logic       probe_valid_out;
        logic       mark_result;
    } out_item_t;

    typedef struct packed {
        logic        fuse_mode;
        logic [7:0]  startup_absent_needed;
        logic [7:0]  insert_samples_needed;
        logic [31:0] absent_grace_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  stable_state;
        logic [1:0]  cand_state;
        logic [7:0]  cand_count;
        logic [31:0] cand_start_ms;
        logic [7:0]  startup_absent_count;
        logic        initial_done;
        logic        last_valid;
    } ctx_t;

endpackage

`default_nettype wire

[rtl/psd_step.sv]
`default_nettype none

module psd_step (
    input  var psd_pkg::cfg_t      cfg,
    input  var psd_pkg::ctx_t      ctx,
    input  var psd_pkg::in_item_t  item,
    output psd_pkg::ctx_t          ctx_out,
    output psd_pkg::out_item_t     result
);

    logic [1:0] sample;

    always_comb
    begin
        if (!item.probe_ok)
        begin
            sample = psd_pkg::ST_ABSENT;
        end
        else if (item.service_word == psd_pkg::SERVICE_CODE)
        begin
            sample = psd_pkg::ST_SERVICE;
        end
        else if (!cfg.fuse_mode || item.marker_word == psd_pkg::MARKER_BLANK)
        begin
            sample = psd_pkg::ST_NEW;
        end
        else
        begin
            sample = psd_pkg::ST_CONSUMED;
        end
    end

    always_comb
    begin
        logic confirmed;
        logic mark_ok;
        ctx_out   = ctx;
        confirmed = 1'b0;
        mark_ok   = 1'b0;
        if (item.action)
        begin
            if (!cfg.fuse_mode)
            begin
                mark_ok = 1'b1;
            end
            else if (!item.probe_ok)
            begin
                ctx_out.cand_state    = ctx.stable_state;
                ctx_out.cand_count    = '0;
                ctx_out.cand_start_ms = '0;
            end
            else
            begin
                ctx_out.stable_state = psd_pkg::ST_CONSUMED;
                ctx_out.cand_state   = psd_pkg::ST_CONSUMED;
                ctx_out.cand_count   = '0;
                mark_ok              = 1'b1;
            end
        end
        else
        begin
            ctx_out.last_valid = item.probe_ok;
            if (!ctx.initial_done && !item.probe_ok)
            begin
                ctx_out.cand_state = psd_pkg::ST_ABSENT;
                ctx_out.cand_count = '0;
                if (ctx.startup_absent_count != psd_pkg::COUNT_MAX)
                begin
                    ctx_out.startup_absent_count = ctx.startup_absent_count + 8'd1;
                end
                if (ctx_out.startup_absent_count >= cfg.startup_absent_needed)
                begin
                    ctx_out.stable_state = psd_pkg::ST_ABSENT;
                    ctx_out.initial_done = 1'b1;
                end
            end
            else
            begin
                if (item.probe_ok)
                begin
                    ctx_out.startup_absent_count = '0;
                end
                if (sample == ctx.stable_state)
                begin
                    ctx_out.cand_state    = sample;
                    ctx_out.cand_count    = '0;
                    ctx_out.cand_start_ms = '0;
                    ctx_out.initial_done  = 1'b1;
                end
                else
                begin
                    if (sample != ctx.cand_state)
                    begin
                        ctx_out.cand_state    = sample;
                        ctx_out.cand_count    = 8'd1;
                        ctx_out.cand_start_ms = item.now_ms;
                    end
                    else if (ctx.cand_count != psd_pkg::COUNT_MAX)
                    begin
                        ctx_out.cand_count = ctx.cand_count + 8'd1;
                    end
                    if (sample == psd_pkg::ST_ABSENT)
                    begin
                        confirmed = (item.now_ms - ctx_out.cand_start_ms)
                                    >= cfg.absent_grace_ms;
                    end
                    else
                    begin
                        confirmed = ctx_out.cand_count >= cfg.insert_samples_needed;
                    end
                    if (confirmed)
                    begin
                        ctx_out.stable_state  = sample;
                        ctx_out.cand_count    = '0;
                        ctx_out.cand_start_ms = '0;
                        ctx_out.initial_done  = 1'b1;
                    end
                end
            end
        end
        result.stable_out      = ctx_out.stable_state;
        result.first_confirmed = ctx_out.initial_done;
        result.probe_valid_out = ctx_out.last_valid;
        result.mark_result     = mark_ok;
    end

endmodule

`default_nettype wire

[rtl/presence_state_debouncer.sv]
`default_nettype none

// Debounces a stream of presence probe outcomes into a confirmed state (absent, new,
// consumed, service) and reports the state after every item. Each transfer is
// captured in an input register, processed by one level of compare, saturating count
// and 32-bit elapsed-time logic, and written to a result register, so one item is
// taken per cycle; the input only stalls while a result waits to be taken.
// Registers sit at byte addresses 0x0 fuse_mode, 0x4 startup_absent_needed,
// 0x8 insert_samples_needed and 0xC absent_grace_ms; the user must write them
// only while idle, and the block itself does not enforce this.
module presence_state_debouncer (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [psd_pkg::ADDR_W-1:0]      paddr,
    input  wire [psd_pkg::DATA_W-1:0]      pwdata,
    output logic [psd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  wire                            item_valid,
    output logic                           item_ready,
    input  var psd_pkg::in_item_t          item,
    output logic                           result_valid,
    input  wire                            result_ready,
    output psd_pkg::out_item_t             result
);

    psd_pkg::cfg_t      cfg_reg;
    psd_pkg::ctx_t      ctx_reg;
    psd_pkg::ctx_t      ctx_next;
    psd_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    psd_pkg::out_item_t out_reg;
    psd_pkg::out_item_t out_next;
    logic               out_valid_reg;
    logic               advance;
    logic               cfg_wr;

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            psd_pkg::REG_FUSE_MODE:     prdata = {31'd0, cfg_reg.fuse_mode};
            psd_pkg::REG_STARTUP_ABS:   prdata = {24'd0, cfg_reg.startup_absent_needed};
            psd_pkg::REG_INSERT_NEEDED: prdata = {24'd0, cfg_reg.insert_samples_needed};
            psd_pkg::REG_ABSENT_GRACE:  prdata = cfg_reg.absent_grace_ms;
            default:                    prdata = '0;
        endcase
    end

    psd_step u_step (
        .cfg     (cfg_reg),
        .ctx     (ctx_reg),
        .item    (in_reg),
        .ctx_out (ctx_next),
        .result  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fuse_mode             <= psd_pkg::FUSE_MODE_RST;
            cfg_reg.startup_absent_needed <= psd_pkg::STARTUP_ABS_RST;
            cfg_reg.insert_samples_needed <= psd_pkg::INSERT_NEEDED_RST;
            cfg_reg.absent_grace_ms       <= psd_pkg::ABSENT_GRACE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                psd_pkg::REG_FUSE_MODE:     cfg_reg.fuse_mode <= pwdata[0];
                psd_pkg::REG_STARTUP_ABS:   cfg_reg.startup_absent_needed <= pwdata[7:0];
                psd_pkg::REG_INSERT_NEEDED: cfg_reg.insert_samples_needed <= pwdata[7:0];
                psd_pkg::REG_ABSENT_GRACE:  cfg_reg.absent_grace_ms <= pwdata;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                ctx_reg       <= ctx_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[sim/presence_checker.sv]
`timescale 1ns / 1ps

module presence_checker
    import psd_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire                pready,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    input  wire                item_valid,
    input  wire                item_ready,
    input  in_item_t           item,
    input  wire                result_valid,
    input  wire                result_ready,
    input  out_item_t          result,
    output int                 fail_count,
    output int                 results_owed
);

    cfg_t      cfg;
    ctx_t      ctx;
    out_item_t expected_states[$];
    out_item_t want;

    function automatic out_item_t advance_presence(in_item_t it);
        logic [1:0]  sample;
        logic [31:0] elapsed;
        logic        confirmed;
        logic        mark_ok;
        out_item_t   res;
        mark_ok = 1'b0;
        if (it.action) begin
            if (!cfg.fuse_mode) begin
                mark_ok = 1'b1;
            end
            else if (!it.probe_ok) begin
                ctx.cand_state    = ctx.stable_state;
                ctx.cand_count    = '0;
                ctx.cand_start_ms = '0;
            end
            else begin
                ctx.stable_state = ST_CONSUMED;
                ctx.cand_state   = ST_CONSUMED;
                ctx.cand_count   = '0;
                mark_ok          = 1'b1;
            end
        end
        else begin
            if (!it.probe_ok)
                sample = ST_ABSENT;
            else if (it.service_word == SERVICE_CODE)
                sample = ST_SERVICE;
            else if (!cfg.fuse_mode || it.marker_word == MARKER_BLANK)
                sample = ST_NEW;
            else
                sample = ST_CONSUMED;
            ctx.last_valid = it.probe_ok;
            if (!ctx.initial_done && !it.probe_ok) begin
                ctx.cand_state = ST_ABSENT;
                ctx.cand_count = '0;
                if (ctx.startup_absent_count != COUNT_MAX)
                    ctx.startup_absent_count = ctx.startup_absent_count + 8'd1;
                if (ctx.startup_absent_count >= cfg.startup_absent_needed) begin
                    ctx.stable_state = ST_ABSENT;
                    ctx.initial_done = 1'b1;
                end
            end
            else begin
                if (it.probe_ok)
                    ctx.startup_absent_count = '0;
                if (sample == ctx.stable_state) begin
                    ctx.cand_state    = sample;
                    ctx.cand_count    = '0;
                    ctx.cand_start_ms = '0;
                    ctx.initial_done  = 1'b1;
                end
                else begin
                    if (sample != ctx.cand_state) begin
                        ctx.cand_state    = sample;
                        ctx.cand_count    = 8'd1;
                        ctx.cand_start_ms = it.now_ms;
                    end
                    else if (ctx.cand_count != COUNT_MAX) begin
                        ctx.cand_count = ctx.cand_count + 8'd1;
                    end
                    elapsed = it.now_ms - ctx.cand_start_ms;
                    if (sample == ST_ABSENT)
                        confirmed = (elapsed >= cfg.absent_grace_ms);
                    else
                        confirmed = (ctx.cand_count >= cfg.insert_samples_needed);
                    if (confirmed) begin
                        ctx.stable_state  = sample;
                        ctx.cand_count    = '0;
                        ctx.cand_start_ms = '0;
                        ctx.initial_done  = 1'b1;
                    end
                end
            end
        end
        res.stable_out      = ctx.stable_state;
        res.first_confirmed = ctx.initial_done;
        res.probe_valid_out = ctx.last_valid;
        res.mark_result     = mark_ok;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.fuse_mode             = FUSE_MODE_RST;
            cfg.startup_absent_needed = STARTUP_ABS_RST;
            cfg.insert_samples_needed = INSERT_NEEDED_RST;
            cfg.absent_grace_ms       = ABSENT_GRACE_RST;
            ctx                       = '0;
            expected_states.delete();
            fail_count                = 0;
            results_owed              = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_FUSE_MODE:     cfg.fuse_mode             = pwdata[0];
                    REG_STARTUP_ABS:   cfg.startup_absent_needed = pwdata[7:0];
                    REG_INSERT_NEEDED: cfg.insert_samples_needed = pwdata[7:0];
                    REG_ABSENT_GRACE:  cfg.absent_grace_ms       = pwdata[31:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result transfer: stable=%0d first=%0b valid=%0b mark=%0b",
                                 result.stable_out, result.first_confirmed,
                                 result.probe_valid_out, result.mark_result);
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (want.stable_out !== result.stable_out
                        || want.first_confirmed !== result.first_confirmed
                        || want.probe_valid_out !== result.probe_valid_out
                        || want.mark_result !== result.mark_result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch at %0t: expected stable=%0d first=%0b valid=%0b mark=%0b, got stable=%0d first=%0b valid=%0b mark=%0b",
                                     $realtime, want.stable_out, want.first_confirmed,
                                     want.probe_valid_out, want.mark_result,
                                     result.stable_out, result.first_confirmed,
                                     result.probe_valid_out, result.mark_result);
                    end
                end
            end
            if (item_valid && item_ready)
                expected_states.push_back(advance_presence(item));
            results_owed = expected_states.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import psd_pkg::*;

    localparam int RUN_LIMIT = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_ready;
    in_item_t          item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    out_item_t         result;
    logic              quiet = 1'b0;
    int                fail_count;
    int                results_owed;
    int                cycles = 0;

    presence_state_debouncer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    presence_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= quiet || ($urandom_range(99) >= 8);
    end

    function automatic in_item_t make_item(logic act, logic ok, logic [15:0] svc,
                                           logic [15:0] mark, logic [31:0] now);
        in_item_t it;
        it.action       = act;
        it.probe_ok     = ok;
        it.service_word = svc;
        it.marker_word  = mark;
        it.now_ms       = now;
        return it;
    endfunction

    function automatic in_item_t probe_of(logic [1:0] kind, logic [31:0] now);
        logic [31:0] rnd;
        in_item_t    it;
        rnd             = $urandom();
        it.action       = 1'b0;
        it.probe_ok     = (kind != ST_ABSENT);
        it.service_word = rnd[15:0];
        it.marker_word  = rnd[31:16];
        it.now_ms       = now;
        if (kind == ST_SERVICE)
            it.service_word = SERVICE_CODE;
        else if (kind != ST_ABSENT && it.service_word == SERVICE_CODE)
            it.service_word = ~SERVICE_CODE;
        if (kind == ST_NEW)
            it.marker_word = MARKER_BLANK;
        else if (kind == ST_CONSUMED && it.marker_word == MARKER_BLANK)
            it.marker_word = '0;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while (!quiet && $urandom_range(99) < 8)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
        @(negedge clk);
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic fuse, input logic [7:0] startup_needed,
                              input logic [7:0] insert_needed, input logic [31:0] grace);
        wait_drained();
        apb_write(REG_FUSE_MODE, {31'd0, fuse});
        apb_write(REG_STARTUP_ABS, {24'd0, startup_needed});
        apb_write(REG_INSERT_NEEDED, {24'd0, insert_needed});
        apb_write(REG_ABSENT_GRACE, grace);
    endtask

    task automatic run_directed();
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'd0));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'hFFFF, 32'd1));
        set_config(1'b1, 8'd2, 8'd5, 32'd1000);
        send_item(make_item(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 32'd2));
        send_item(make_item(1'b0, 1'b0, 16'h5A5A, 16'hA5A5, 32'd3));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'h0000, 32'd10));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'hFFFF, 32'd11));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'h1234, 32'd12));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'h8001, 32'd13));
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'h7FFE, 32'd14));
        send_item(make_item(1'b0, 1'b1, 16'hFFFF, MARKER_BLANK, 32'd15));
        send_item(make_item(1'b0, 1'b1, 16'h0000, 16'h0000, 32'd16));
        send_item(make_item(1'b1, 1'b1, 16'h0000, 16'h0000, 32'd17));
        send_item(make_item(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 32'd18));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'hFFFF_FF00));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_0100));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_0400));
        set_config(1'b0, 8'd1, 8'd1, 32'hFFFF_FFFF);
        send_item(make_item(1'b1, 1'b0, 16'h0000, 16'h0000, 32'd0));
        send_item(make_item(1'b0, 1'b1, 16'h1234, 16'h0000, 32'd1));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'd5));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'd4));
        set_config(1'b1, 8'd255, 8'd1, 32'd0);
        send_item(make_item(1'b0, 1'b1, SERVICE_CODE, 16'h0000, 32'd100));
        send_item(make_item(1'b0, 1'b0, 16'h0000, 16'h0000, 32'd100));
        send_item(make_item(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    endtask

    task automatic run_random_phase(input int phase, input int count);
        logic        fuse;
        logic [7:0]  startup_needed;
        logic [7:0]  insert_needed;
        logic [31:0] grace;
        logic [31:0] now;
        logic [31:0] step;
        logic [31:0] rnd;
        logic [31:0] rnd2;
        logic [1:0]  kind;
        in_item_t    it;
        int          sent;
        int          run_len;
        int          pick;
        fuse           = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(1));
        startup_needed = (phase == 0) ? 8'd1 : (phase == 1) ? 8'd255
                                      : 8'($urandom_range(1, 255));
        insert_needed  = (phase == 2) ? 8'd255 : (phase == 3) ? 8'd1
                                      : 8'($urandom_range(1, 8));
        grace          = (phase == 4) ? 32'd0 : (phase == 5) ? 32'hFFFF_FFFF
                                      : 32'($urandom_range(0, 60));
        set_config(fuse, startup_needed, insert_needed, grace);
        quiet = (phase == 3);
        now   = (phase == 6) ? 32'hFFFF_FF80 : $urandom();
        step  = (grace > 32'd400) ? 32'd100 : grace / 4 + 32'd1;
        sent  = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(49) == 0)
                now = $urandom();
            else
                now = now + $urandom_range(0, step);
            if (pick < 8)
            begin
                rnd             = $urandom();
                rnd2            = $urandom();
                it.action       = rnd[0];
                it.probe_ok     = rnd[1];
                it.service_word = rnd[31:16];
                it.marker_word  = rnd2[15:0];
                it.now_ms       = rnd[2] ? now : $urandom();
                send_item(it);
                sent++;
            end
            else if (pick < 16)
            begin
                it          = probe_of(2'($urandom_range(3)), now);
                it.action   = 1'b1;
                it.probe_ok = ($urandom_range(99) < 75);
                send_item(it);
                sent++;
            end
            else
            begin
                kind = 2'($urandom_range(3));
                if (insert_needed > 8'd16)
                    run_len = $urandom_range(insert_needed - 4, insert_needed + 8);
                else
                    run_len = $urandom_range(1, insert_needed + 2);
                while (run_len > 0 && sent < count)
                begin
                    send_item(probe_of(kind, now));
                    now = now + $urandom_range(0, step);
                    sent++;
                    run_len--;
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int phase;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (phase = 0; phase < 8; phase++)
            run_random_phase(phase, (phase == 2) ? 700 : 180);
        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
